>>> hdl/galvo_line_ramp_generator_core_macros.svh
// Assertion macros used by the checker file.
`ifndef GALVO_LINE_RAMP_GENERATOR_CORE_MACROS_SVH
`define GALVO_LINE_RAMP_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GLRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glrg assertion failed");

// Next-cycle implication, disabled during reset.
`define GLRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glrg assertion failed");

`endif

>>> hdl/glrg_pkg.sv
`timescale 1ns / 1ps

package glrg_pkg;

  // Field and register widths
  localparam int N_W         = 13;
  localparam int FILL_W      = 17;
  localparam int AMP_W       = 15;
  localparam int CFG_W       = 17;
  localparam int ADDR_W      = 2;
  localparam int MAG_W       = 13;
  localparam int Q_W         = 15;
  localparam int PROD_W      = AMP_W + MAG_W;
  localparam int X_W         = 16;
  localparam int OUT_IDX_W   = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_SAMPLES = 2'd0;
  localparam logic [ADDR_W-1:0] REG_FILL    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_AMP     = 2'd2;

  // Reset values
  localparam logic [N_W-1:0]    SAMPLES_RST = 13'd512;
  localparam logic [FILL_W-1:0] FILL_RST    = 17'd52429;
  localparam logic [AMP_W-1:0]  AMP_RST     = 15'd16384;

  // Q16 one
  localparam logic [FILL_W-1:0] FILL_ONE = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Clamped configuration seen by the datapath
  typedef struct packed {
    logic [N_W-1:0]    n_c;
    logic [FILL_W-1:0] fill_c;
    logic [AMP_W-1:0]  amp;
  } cfg_t;

endpackage

>>> hdl/glrg_cfg.sv
`timescale 1ns / 1ps

module glrg_cfg #(
  parameter int MAX_LINE_SAMPLES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [glrg_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [glrg_pkg::CFG_W-1:0]    cfg_wdata,
  output glrg_pkg::cfg_t                cfg
);

  localparam int NW = glrg_pkg::N_W;
  localparam int FW = glrg_pkg::FILL_W;
  localparam int AW = glrg_pkg::AMP_W;
  localparam logic [FW-1:0] MAX_L = FW'(MAX_LINE_SAMPLES);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_LINE_SAMPLES);

  logic [NW-1:0] samples;
  logic [FW-1:0] fill;
  logic [AW-1:0] amp;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= glrg_pkg::SAMPLES_RST;
      fill    <= glrg_pkg::FILL_RST;
      amp     <= glrg_pkg::AMP_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        glrg_pkg::REG_SAMPLES: samples <= cfg_wdata[NW-1:0];
        glrg_pkg::REG_FILL:    fill    <= cfg_wdata[FW-1:0];
        glrg_pkg::REG_AMP:     amp     <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp line length and fill
  always_comb begin
    if (samples == '0) begin
      cfg.n_c = NW'(1);
    end else if (FW'(samples) > MAX_L) begin
      cfg.n_c = MAX_N;
    end else begin
      cfg.n_c = samples;
    end
    cfg.fill_c = (fill > glrg_pkg::FILL_ONE) ? glrg_pkg::FILL_ONE : fill;
    cfg.amp    = amp;
  end

endmodule

>>> hdl/glrg_div.sv
`timescale 1ns / 1ps

module glrg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [glrg_pkg::PROD_W-1:0]   dividend,
  input  logic [glrg_pkg::MAG_W-1:0]    divisor,
  output logic                          done,
  output logic [glrg_pkg::Q_W-1:0]      quotient
);

  localparam int MW    = glrg_pkg::MAG_W;
  localparam int QW    = glrg_pkg::Q_W;
  localparam int CNT_W = $clog2(QW);

  logic [MW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [MW-1:0]    den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MW:0]      trial;
  logic [MW+1:0]    diff;
  logic             fits;
  logic [MW-1:0]    rem_next;

  // One quotient bit per cycle: shift in the next dividend bit, try subtract
  always_comb begin
    trial    = {rem, quo[QW-1]};
    diff     = {1'b0, trial} - {2'b0, den};
    fits     = !diff[MW+1];
    rem_next = fits ? diff[MW-1:0] : trial[MW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers; the upper dividend bits stay below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[glrg_pkg::PROD_W-1:QW];
      quo <= dividend[QW-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> hdl/galvo_line_ramp_generator_core.sv
`timescale 1ns / 1ps

// Galvo X-axis line ramp generator.
// Input stream: one request per sample-clock tick; tdata[0] is restart, which
// sets the sample index to zero before that tick. Output stream: one result per
// request, tdata = x_sample (signed DAC code) then sample_index, tlast marks
// the last sample of a line, after which the index wraps to zero.
// Config port: cfg_wen / cfg_addr / cfg_wdata write samples_per_line (0),
// fill_fraction (1) and amplitude (2); write only while no request is in work.
// Each request goes through a short sequencer: active length (one multiply),
// ramp setup, amplitude multiply, then a restoring divider that makes one
// quotient bit per cycle and flags done with the last bit. A new request is
// taken only after the previous result has gone into the output register.
// The output register holds a finished result while the receiver stalls; the
// next request is accepted meanwhile, and its result waits in the last step
// until the register frees.
// Reset (synchronous) empties the output, returns the index to zero and loads
// the register defaults (512 samples, fill 0.8, amplitude 16384).
module galvo_line_ramp_generator_core #(
  parameter int MAX_LINE_SAMPLES = 4096,
  parameter int DAC_BITS         = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [glrg_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [glrg_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [glrg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] restart
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] x_sample, [27:16] sample_index
  output logic [glrg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int NW    = glrg_pkg::N_W;
  localparam int FW    = glrg_pkg::FILL_W;
  localparam int MW    = glrg_pkg::MAG_W;
  localparam int QW    = glrg_pkg::Q_W;
  localparam int XW    = glrg_pkg::X_W;
  localparam int OIW   = glrg_pkg::OUT_IDX_W;
  localparam int PW    = glrg_pkg::PROD_W;
  localparam int AP_W  = NW + FW;
  localparam int IDX_W = ($clog2(MAX_LINE_SAMPLES) < NW) ? $clog2(MAX_LINE_SAMPLES) : NW;
  localparam logic [31:0] DAC_LIM = 32'((64'd1 << (DAC_BITS - 1)) - 64'd1);

  glrg_pkg::cfg_t   cfg;
  glrg_pkg::state_t state, state_next;

  logic              restart_q;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  smp_idx;
  logic              line_end_q;
  logic [NW-1:0]     active;
  logic [MW-1:0]     mag;
  logic [MW-1:0]     den;
  logic              neg;
  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     quotient;
  logic              load_out;
  logic [XW-1:0]     out_x;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;

  logic [NW-1:0]     idx_ext;
  logic [AP_W-1:0]   act_prod;
  logic              in_ramp;
  logic [NW-1:0]     f_len;
  logic [NW-1:0]     j_off;
  logic [MW+1:0]     num;
  logic [MW+1:0]     num_abs;
  logic              last;
  logic [QW-1:0]     mag_sat;
  logic [XW-1:0]     x_val;
  logic [PW-1:0]     product;

  glrg_cfg #(
    .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Amplitude times ramp magnitude feeds the divider load directly
  assign product = PW'(cfg.amp) * PW'(mag);

  glrg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // Ramp arithmetic
  always_comb begin
    idx_ext  = NW'(idx);
    act_prod = AP_W'(cfg.n_c) * AP_W'(cfg.fill_c);
    in_ramp  = idx_ext < active;
    f_len    = cfg.n_c - active;
    j_off    = idx_ext - active;
    if (in_ramp) begin
      num = {1'b0, idx_ext, 1'b0} - {2'b0, active};
    end else begin
      num = {2'b0, f_len} - {1'b0, j_off, 1'b0};
    end
    num_abs = num[MW+1] ? (~num + 1'b1) : num;
    last    = idx_ext == (cfg.n_c - 1'b1);
  end

  // Saturate to DAC range and apply sign
  always_comb begin
    mag_sat = (32'(quotient) > DAC_LIM) ? QW'(DAC_LIM) : quotient;
    x_val   = neg ? (~{1'b0, mag_sat} + 1'b1) : {1'b0, mag_sat};
  end

  // Index update: fix up before the tick, advance after it
  always_comb begin
    idx_next = idx;
    case (state)
      glrg_pkg::ST_ACTIVE: begin
        if (restart_q || (idx_ext >= cfg.n_c)) begin
          idx_next = '0;
        end
      end
      glrg_pkg::ST_SETUP: begin
        idx_next = last ? '0 : (idx + 1'b1);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glrg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state)
      glrg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = glrg_pkg::ST_ACTIVE;
        end
      end
      glrg_pkg::ST_ACTIVE: state_next = glrg_pkg::ST_SETUP;
      glrg_pkg::ST_SETUP:  state_next = glrg_pkg::ST_MUL;
      glrg_pkg::ST_MUL: begin
        div_start  = 1'b1;
        state_next = glrg_pkg::ST_DIV;
      end
      glrg_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = glrg_pkg::ST_DONE;
        end
      end
      glrg_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = glrg_pkg::ST_IDLE;
        end
      end
      default: state_next = glrg_pkg::ST_IDLE;
    endcase
  end

  // Index counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // Per-request datapath registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      restart_q <= s_axis_tdata[0];
    end
    if (state == glrg_pkg::ST_ACTIVE) begin
      active <= act_prod[NW+15:16];
    end
    if (state == glrg_pkg::ST_SETUP) begin
      mag        <= num_abs[MW-1:0];
      neg        <= num[MW+1];
      den        <= in_ramp ? active : f_len;
      smp_idx    <= idx;
      line_end_q <= last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x    <= x_val;
      out_idx  <= smp_idx;
      out_last <= line_end_q;
    end
  end

  assign m_axis_tdata = {(glrg_pkg::OUT_TDATA_W - XW - OIW)'(0), OIW'(out_idx), out_x};
  assign m_axis_tlast = out_last;

endmodule

>>> hdl/glrg_checker.sv
`timescale 1ns / 1ps

`include "galvo_line_ramp_generator_core_macros.svh"

module glrg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [glrg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tlast
);

  logic seen_end;

  // Track whether the last result taken closed a line
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_end <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen_end <= m_axis_tlast;
    end
  end

  // Stalled result holds
  `GLRG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // One request in work at a time
  `GLRG_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Result after a line end starts the next line
  `GLRG_ASSERT_NOW(a_wrap_zero, m_axis_tvalid && seen_end, m_axis_tdata[27:16] == 12'd0)
  // Symmetric DAC range: most negative code never appears
  `GLRG_ASSERT_NOW(a_dac_range, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000)

endmodule

bind galvo_line_ramp_generator_core glrg_checker u_glrg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SAMPLES  = 4096;
  localparam int DAC_WIDTH    = 16;
  localparam int RANDOM_ITEMS = 1380;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 40;

  localparam int CW = glrg_pkg::CFG_W;
  localparam int XW = glrg_pkg::X_W;
  localparam int IW = glrg_pkg::OUT_IDX_W;

  // Index past the register list; writes there must change nothing
  localparam logic [glrg_pkg::ADDR_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic [IW-1:0]        idx;
    logic                 last;
  } drive_sample_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wen = 1'b0;
  logic [glrg_pkg::ADDR_W-1:0]      cfg_addr = glrg_pkg::REG_SAMPLES;
  logic [CW-1:0]                    cfg_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [glrg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [glrg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // Shadow of the block's registers and its line position
  logic [glrg_pkg::N_W-1:0]    line_len = glrg_pkg::SAMPLES_RST;
  logic [glrg_pkg::FILL_W-1:0] fill_q16 = glrg_pkg::FILL_RST;
  logic [glrg_pkg::AMP_W-1:0]  amp      = glrg_pkg::AMP_RST;
  logic [IW-1:0]               line_pos = '0;

  drive_sample_t expected_samples[$];
  int            errors = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            drain_left = 0;
  logic          no_gaps = 1'b0;

  galvo_line_ramp_generator_core #(
    .MAX_LINE_SAMPLES(MAX_SAMPLES),
    .DAC_BITS        (DAC_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Next drive sample for one tick; advances the line position
  function automatic drive_sample_t ramp_sample(input logic restart);
    longint n, fl, act, i, a, f, j, x, lim;
    drive_sample_t s;
    n = line_len;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    fl = fill_q16;
    if (fl > glrg_pkg::FILL_ONE) fl = glrg_pkg::FILL_ONE;
    act = (n * fl) >>> 16;
    a = amp;
    if (restart) line_pos = '0;
    if (longint'(line_pos) >= n) line_pos = '0;
    i = line_pos;
    if (i < act) begin
      x = (a * (2 * i - act)) / act;
    end else begin
      f = n - act;
      j = i - act;
      x = (a * (f - 2 * j)) / f;
    end
    // clip to the DAC range
    lim = (longint'(1) << (DAC_WIDTH - 1)) - 1;
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    s.x = x[XW-1:0];
    s.idx = i[IW-1:0];
    s.last = (i == n - 1);
    line_pos = s.last ? '0 : IW'(i + 1);
    return s;
  endfunction

  // Load all registers back to back, plus a write to the unused index
  task automatic write_config(input logic [CW-1:0] n, input logic [CW-1:0] fill,
                              input logic [CW-1:0] a);
    cfg_wen <= 1'b1;
    cfg_addr <= glrg_pkg::REG_SAMPLES;
    cfg_wdata <= n;
    @(posedge clk);
    line_len = n[glrg_pkg::N_W-1:0];
    cfg_addr <= REG_NONE;
    cfg_wdata <= CW'($urandom);
    @(posedge clk);
    cfg_addr <= glrg_pkg::REG_FILL;
    cfg_wdata <= fill;
    @(posedge clk);
    fill_q16 = fill[glrg_pkg::FILL_W-1:0];
    cfg_addr <= glrg_pkg::REG_AMP;
    cfg_wdata <= a;
    @(posedge clk);
    amp = a[glrg_pkg::AMP_W-1:0];
    cfg_wen <= 1'b0;
  endtask

  // Send one tick request and record the sample it must produce
  task automatic send_tick(input logic restart);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= glrg_pkg::IN_TDATA_W'(restart);
    do @(posedge clk); while (!s_axis_tready);
    expected_samples.push_back(ramp_sample(restart));
  endtask

  // Drop the request line and wait for every pending sample
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  // Zero length line with fill above one and full amplitude
  task automatic test_single_sample_line();
    write_config(CW'(0), CW'(131071), CW'(32767));
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
  endtask

  // Whole line is flyback
  task automatic test_zero_fill();
    write_config(CW'(3), CW'(0), CW'(32767));
    repeat (4) send_tick(1'b0);
    settle();
  endtask

  // Overlong line saturates, full fill, zero amplitude
  task automatic test_full_fill_long_line();
    write_config(CW'(8191), glrg_pkg::FILL_ONE, CW'(0));
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
  endtask

  // Shrink the line while the index sits past its new end
  task automatic test_index_past_line();
    write_config(CW'(4), CW'(32768), CW'(32767));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    write_config(CW'(2), CW'(32768), CW'(32767));
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  function automatic logic [CW-1:0] pick_line_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CW'($urandom_range(1, 16));
    if (r < 80) return CW'($urandom_range(17, 200));
    if (r < 90) return CW'($urandom_range(201, 4096));
    if (r < 95) return CW'($urandom_range(4097, 8191));
    if (r < 98) return CW'(MAX_SAMPLES);
    return '0;
  endfunction

  function automatic logic [CW-1:0] pick_fill();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return glrg_pkg::FILL_ONE;
    if (r < 25) return CW'($urandom_range(65537, 131071));
    return CW'($urandom_range(0, 65536));
  endfunction

  function automatic logic [CW-1:0] pick_amp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return CW'(32767);
    return CW'($urandom_range(0, 32767));
  endfunction

  // Random settings, each run for one to three lines, cut to 120 ticks, plus up to five more, with sparse restarts
  task automatic test_random_lines();
    int sent;
    int count;
    int eff_len;
    logic [CW-1:0] n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = pick_line_len();
      write_config(n, pick_fill(), pick_amp());
      eff_len = (n == 0) ? 1 : (n > MAX_SAMPLES ? MAX_SAMPLES : int'(n));
      count = eff_len * $urandom_range(1, 3);
      if (count > 120) count = 120;
      count += $urandom_range(0, 5);
      no_gaps = ($urandom_range(0, 5) == 0);
      repeat (count) send_tick($urandom_range(0, 31) == 0);
      sent += count;
      settle();
      no_gaps = 1'b0;
    end
  endtask

  // Receiver side: random stall runs
  always @(posedge clk) begin
    if (drain_left != 0) begin
      m_axis_tready <= 1'b0;
      drain_left <= drain_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) drain_left <= pick_gap();
    end
  end

  // Compare each sample with the oldest expectation
  always @(posedge clk) begin
    drive_sample_t exp_s;
    drive_sample_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[XW-1:0];
      got.idx = m_axis_tdata[XW +: IW];
      got.last = m_axis_tlast;
      if (expected_samples.size() == 0) begin
        errors++;
        if (mismatches < REPORT_MAX)
          $display("unexpected sample: x=%0d idx=%0d last=%0b", got.x, got.idx, got.last);
        mismatches++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (got !== exp_s) begin
          errors++;
          if (mismatches < REPORT_MAX)
            $display("sample mismatch: expected x=%0d idx=%0d last=%0b, got x=%0d idx=%0d last=%0b",
                     exp_s.x, exp_s.idx, exp_s.last, got.x, got.idx, got.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no request or sample moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_single_sample_line();
    test_zero_fill();
    test_full_fill_long_line();
    test_index_past_line();
    test_random_lines();
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += expected_samples.size();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
